// File: src/dwpi_pkg.sv
package dwpi_pkg;

	localparam int FRAC_BITS = 16;
	localparam int LPF_BITS  = 16;
	localparam int WORD_W    = 32;
	localparam int OPND_W    = WORD_W + 1;
	localparam int PROD_W    = 2 * OPND_W;
	localparam int PULSE_W   = 16;
	localparam int DRV_W     = 18;
	localparam int W_W       = 17;
	localparam int UQ_W      = 31;
	localparam int IDX_W     = 3;

	localparam logic [IDX_W-1:0] REG_REF_L = 3'd0;
	localparam logic [IDX_W-1:0] REG_REF_R = 3'd1;
	localparam logic [IDX_W-1:0] REG_KP    = 3'd2;
	localparam logic [IDX_W-1:0] REG_KI    = 3'd3;
	localparam logic [IDX_W-1:0] REG_W     = 3'd4;
	localparam logic [IDX_W-1:0] REG_SPP   = 3'd5;
	localparam logic [IDX_W-1:0] REG_DT    = 3'd6;

	localparam logic [W_W-1:0] W_ONE = W_W'(1) << LPF_BITS;

	localparam logic signed [PROD_W-1:0] DRV_ONE = PROD_W'(1) <<< FRAC_BITS;
	localparam logic signed [PROD_W-1:0] S32_MAX = PROD_W'(32'h7fff_ffff);
	localparam logic signed [PROD_W-1:0] S32_MIN = -S32_MAX - PROD_W'(1);

	typedef struct packed {
		logic signed [WORD_W-1:0] ref_l;
		logic signed [WORD_W-1:0] ref_r;
		logic signed [WORD_W-1:0] kp;
		logic signed [WORD_W-1:0] ki;
		logic [W_W-1:0]           w;
		logic [UQ_W-1:0]          spp;
		logic [UQ_W-1:0]          dt;
	} cfg_t;

	typedef struct packed {
		logic signed [DRV_W-1:0] drive_l;
		logic signed [DRV_W-1:0] drive_r;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SPD_M,
		ST_SPD_P,
		ST_FLT_M0,
		ST_FLT_P0,
		ST_FLT_M1,
		ST_FLT_P1,
		ST_ERR,
		ST_INT_M,
		ST_INT_P,
		ST_P_M,
		ST_P_P,
		ST_I_M,
		ST_I_P,
		ST_DONE
	} state_t;

	function automatic logic signed [WORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
		logic signed [WORD_W-1:0] r;
		if (v > S32_MAX) begin
			r = S32_MAX[WORD_W-1:0];
		end else if (v < S32_MIN) begin
			r = S32_MIN[WORD_W-1:0];
		end else begin
			r = v[WORD_W-1:0];
		end
		return r;
	endfunction

	// round to nearest, ties toward plus infinity
	function automatic logic signed [PROD_W-1:0] rsh_round(input logic signed [PROD_W-1:0] v,
			input int s);
		logic signed [PROD_W-1:0] bias;
		logic signed [PROD_W-1:0] t;
		bias = PROD_W'(1) <<< (s - 1);
		t = v + bias;
		return t >>> s;
	endfunction

endpackage

// File: src/dwpi_mul.sv
module dwpi_mul (
	input  logic                                 clk,
	input  logic signed [dwpi_pkg::OPND_W-1:0]   a,
	input  logic signed [dwpi_pkg::OPND_W-1:0]   b,
	output logic signed [dwpi_pkg::PROD_W-1:0]   prod
);
	import dwpi_pkg::*;

	logic signed [PROD_W-1:0] prod_s1;

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

	assign prod = prod_s1;

endmodule

// File: src/dwpi_core.sv
module dwpi_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  dwpi_pkg::cfg_t                       cfg,
	input  logic                                 start,
	input  logic signed [dwpi_pkg::PULSE_W-1:0]  pulses_left,
	input  logic signed [dwpi_pkg::PULSE_W-1:0]  pulses_right,
	output logic                                 idle,
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output dwpi_pkg::res_t                       res
);
	import dwpi_pkg::*;

	state_t state_q, state_d;
	logic   wheel_q;

	logic signed [PULSE_W-1:0] pulses_q [2];
	logic signed [WORD_W-1:0]  filt_q [2];
	logic signed [WORD_W-1:0]  integ_q [2];
	logic signed [DRV_W-1:0]   drv_q [2];
	logic signed [WORD_W-1:0]  speed_q;
	logic signed [WORD_W-1:0]  err_q;
	logic signed [PROD_W-1:0]  acc_q;

	logic signed [OPND_W-1:0]  opa, opb;
	logic signed [PROD_W-1:0]  prod;
	logic [W_W-1:0]            w_clip, w_rest;
	logic signed [WORD_W-1:0]  spd_sat;
	logic signed [PROD_W-1:0]  drv_sum;
	logic signed [WORD_W-1:0]  ref_sel;

	dwpi_mul u_mul (
		.clk  (clk),
		.a    (opa),
		.b    (opb),
		.prod (prod)
	);

	assign w_clip  = (cfg.w > W_ONE) ? W_ONE : cfg.w;
	assign w_rest  = W_ONE - w_clip;
	assign ref_sel = wheel_q ? cfg.ref_r : cfg.ref_l;
	assign spd_sat = sat32(prod);
	assign drv_sum = acc_q + rsh_round(prod, FRAC_BITS);

	// operand select for the shared multiplier
	always_comb begin
		opa = '0;
		opb = '0;
		case (state_q)
			ST_SPD_M: begin
				opa = OPND_W'(pulses_q[wheel_q]);
				opb = $signed({2'b00, cfg.spp});
			end
			ST_FLT_M0: begin
				opa = $signed({{(OPND_W-W_W){1'b0}}, w_clip});
				opb = OPND_W'(filt_q[wheel_q]);
			end
			ST_FLT_M1: begin
				opa = $signed({{(OPND_W-W_W){1'b0}}, w_rest});
				opb = OPND_W'(speed_q);
			end
			ST_INT_M: begin
				opa = OPND_W'(err_q);
				opb = $signed({2'b00, cfg.dt});
			end
			ST_P_M: begin
				opa = OPND_W'(err_q);
				opb = OPND_W'(cfg.kp);
			end
			ST_I_M: begin
				opa = OPND_W'(integ_q[wheel_q]);
				opb = OPND_W'(cfg.ki);
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (start) state_d = ST_SPD_M;
			ST_SPD_M:  state_d = ST_SPD_P;
			ST_SPD_P:  state_d = ST_FLT_M0;
			ST_FLT_M0: state_d = ST_FLT_P0;
			ST_FLT_P0: state_d = ST_FLT_M1;
			ST_FLT_M1: state_d = ST_FLT_P1;
			ST_FLT_P1: state_d = ST_ERR;
			ST_ERR:    state_d = ST_INT_M;
			ST_INT_M:  state_d = ST_INT_P;
			ST_INT_P:  state_d = ST_P_M;
			ST_P_M:    state_d = ST_P_P;
			ST_P_P:    state_d = ST_I_M;
			ST_I_M:    state_d = ST_I_P;
			ST_I_P:    state_d = wheel_q ? ST_DONE : ST_SPD_M;
			ST_DONE:   if (res_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wheel_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_I_P) begin
				wheel_q <= ~wheel_q;
			end
		end
	end

	// loop state: filtered speeds and integrals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q[0]  <= '0;
			filt_q[1]  <= '0;
			integ_q[0] <= '0;
			integ_q[1] <= '0;
		end else begin
			if (state_q == ST_FLT_P1) begin
				filt_q[wheel_q] <= sat32(rsh_round(acc_q + prod, LPF_BITS));
			end
			if (state_q == ST_INT_P) begin
				integ_q[wheel_q] <= sat32(PROD_W'(integ_q[wheel_q]) +
					rsh_round(prod, FRAC_BITS));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			pulses_q[0] <= pulses_left;
			pulses_q[1] <= pulses_right;
		end
		case (state_q)
			ST_SPD_P: begin
				// left wheel is mirrored: negate, and clip the one value that overflows
				if (!wheel_q) begin
					speed_q <= (spd_sat == S32_MIN[WORD_W-1:0]) ? S32_MAX[WORD_W-1:0]
						: -spd_sat;
				end else begin
					speed_q <= spd_sat;
				end
			end
			ST_FLT_P0: acc_q <= prod;
			ST_ERR: begin
				err_q <= sat32(PROD_W'(ref_sel) - PROD_W'(filt_q[wheel_q]));
			end
			ST_P_P: acc_q <= rsh_round(prod, FRAC_BITS);
			ST_I_P: begin
				if (drv_sum > DRV_ONE) begin
					drv_q[wheel_q] <= DRV_ONE[DRV_W-1:0];
				end else if (drv_sum < -DRV_ONE) begin
					drv_q[wheel_q] <= -DRV_ONE[DRV_W-1:0];
				end else begin
					drv_q[wheel_q] <= drv_sum[DRV_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign idle          = (state_q == ST_IDLE);
	assign res_valid     = (state_q == ST_DONE);
	assign res.drive_l   = drv_q[0];
	assign res.drive_r   = drv_q[1];

	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && !res_ready |=> state_q == ST_DONE)
		else $error("result dropped before it was taken");

	a_right_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_I_P && wheel_q |=> state_q == ST_DONE && !wheel_q)
		else $error("sequencer did not finish after right wheel");

	a_idle_left: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !wheel_q)
		else $error("wheel select not back to left when idle");

	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> PROD_W'(drv_q[0]) <= DRV_ONE && PROD_W'(drv_q[0]) >= -DRV_ONE
			&& PROD_W'(drv_q[1]) <= DRV_ONE && PROD_W'(drv_q[1]) >= -DRV_ONE)
		else $error("drive outside plus or minus one");

endmodule

// File: src/dual_wheel_pi_speed_loop_unit.sv
// Dual-wheel PI speed loop with low-pass filtered encoder speeds.
// Input stream (s_*): one request per control tick carrying both encoder
// pulse counts. Output stream (m_*): one request per tick carrying the
// saturated left and right drive values, signed Q2.16.
// Config channel (cfg_*): write register cfg_index with cfg_data; always
// ready. Write only while no tick is in flight. Index 7 is ignored.
// Structure: both wheels run through one shared 33x33 multiplier under a
// sequencer of 13 steps per wheel: multiply steps each followed by a post
// step, and one error step. A finished result moves into the output register
// and shows on m_* in the next cycle; s_tready is high only while the
// sequencer is idle, so a new tick is taken only after the last one is done.
// A finished result waits in the output register; the next tick may be
// taken and computed meanwhile, and it holds in its last step until the
// output register frees up, so a stalled receiver loses nothing.
// Reset clears filter and integral state, loads the default registers and
// empties the output register.
module dual_wheel_pi_speed_loop_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] pulses_left, [31:16] pulses_right
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [17:0] drive_left, [35:18] drive_right, rest zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import dwpi_pkg::*;

	cfg_t cfg_q;
	res_t res, out_q;
	logic out_valid_q;
	logic core_idle, res_valid, res_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ref_l <= -32'sd15401;
			cfg_q.ref_r <= -32'sd15401;
			cfg_q.kp    <= 32'sd720896;
			cfg_q.ki    <= '0;
			cfg_q.w     <= 17'd26214;
			cfg_q.spp   <= 31'd1638;
			cfg_q.dt    <= 31'd1311;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_REF_L: cfg_q.ref_l <= cfg_data;
				REG_REF_R: cfg_q.ref_r <= cfg_data;
				REG_KP:    cfg_q.kp    <= cfg_data;
				REG_KI:    cfg_q.ki    <= cfg_data;
				REG_W:     cfg_q.w     <= cfg_data[W_W-1:0];
				REG_SPP:   cfg_q.spp   <= cfg_data[UQ_W-1:0];
				REG_DT:    cfg_q.dt    <= cfg_data[UQ_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign s_tready  = core_idle;
	assign res_ready = !out_valid_q || m_tready;

	dwpi_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.start        (s_tvalid && s_tready),
		.pulses_left  (s_tdata[15:0]),
		.pulses_right (s_tdata[31:16]),
		.idle         (core_idle),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_q.drive_r, out_q.drive_l};

endmodule

// File: sim/tb.sv
module tb;
	import dwpi_pkg::*;

	typedef logic signed [79:0] wide_t;
	typedef enum {MODE_TYPICAL, MODE_WIDE, MODE_EXTREME} phase_mode_t;

	localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int RAND_PHASES  = 14;
	localparam int PHASE_ITEMS  = 60;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 40;

	class drive_scoreboard;
		cfg_t regs;
		logic signed [WORD_W-1:0] filt_l, filt_r, integ_l, integ_r;
		res_t expected_drives[$];
		int fail_count;

		function void clear();
			regs.ref_l = -15401;
			regs.ref_r = -15401;
			regs.kp    = 720896;
			regs.ki    = 0;
			regs.w     = 26214;
			regs.spp   = 1638;
			regs.dt    = 1311;
			filt_l     = '0;
			filt_r     = '0;
			integ_l    = '0;
			integ_r    = '0;
			fail_count = 0;
			expected_drives.delete();
		endfunction

		function void note_reg(logic [IDX_W-1:0] idx, logic [31:0] data);
			case (idx)
				REG_REF_L: regs.ref_l = data;
				REG_REF_R: regs.ref_r = data;
				REG_KP:    regs.kp = data;
				REG_KI:    regs.ki = data;
				REG_W:     regs.w = data[W_W-1:0];
				REG_SPP:   regs.spp = data[UQ_W-1:0];
				REG_DT:    regs.dt = data[UQ_W-1:0];
				default: ;
			endcase
		endfunction

		// nearest, ties go up
		function wide_t round_shift(wide_t v, int s);
			return (v + (wide_t'(1) <<< (s - 1))) >>> s;
		endfunction

		function logic signed [WORD_W-1:0] clamp32(wide_t v);
			wide_t hi, lo;
			hi = 2147483647;
			lo = -hi - 1;
			if (v > hi) return hi[WORD_W-1:0];
			if (v < lo) return lo[WORD_W-1:0];
			return v[WORD_W-1:0];
		endfunction

		function logic signed [DRV_W-1:0] wheel_drive(wide_t speed,
				logic signed [WORD_W-1:0] target,
				inout logic signed [WORD_W-1:0] filt,
				inout logic signed [WORD_W-1:0] integ);
			wide_t w, acc, err, sum, gain, held, one, d;
			one = wide_t'(1) <<< FRAC_BITS;
			// weight above one holds the filter
			if (regs.w > W_ONE) w = W_ONE;
			else w = regs.w;
			held = filt;
			acc = w * held + ((wide_t'(1) <<< LPF_BITS) - w) * speed;
			filt = clamp32(round_shift(acc, LPF_BITS));
			err = target;
			held = filt;
			err = clamp32(err - held);
			sum = integ;
			gain = regs.dt;
			sum = sum + round_shift(err * gain, FRAC_BITS);
			integ = clamp32(sum);
			held = integ;
			gain = $signed(regs.kp);
			d = round_shift(err * gain, FRAC_BITS);
			gain = $signed(regs.ki);
			d = d + round_shift(held * gain, FRAC_BITS);
			if (d > one) d = one;
			else if (d < -one) d = -one;
			return d[DRV_W-1:0];
		endfunction

		function void note_tick(logic signed [PULSE_W-1:0] pl, logic signed [PULSE_W-1:0] pr);
			wide_t pulses, rate, speed_l, speed_r;
			res_t drives;
			rate = regs.spp;
			pulses = pl;
			// left wheel is mirrored: saturate, negate, saturate again
			speed_l = clamp32(pulses * rate);
			speed_l = clamp32(-speed_l);
			pulses = pr;
			speed_r = clamp32(pulses * rate);
			drives.drive_l = wheel_drive(speed_l, regs.ref_l, filt_l, integ_l);
			drives.drive_r = wheel_drive(speed_r, regs.ref_r, filt_r, integ_r);
			expected_drives.push_back(drives);
		endfunction

		function void check_drive(logic [39:0] data);
			res_t want;
			logic signed [DRV_W-1:0] got_l, got_r;
			got_l = data[DRV_W-1:0];
			got_r = data[2*DRV_W-1:DRV_W];
			if (expected_drives.size() == 0) begin
				$error("drive request with nothing expected: left %0d right %0d", got_l, got_r);
				fail_count++;
				return;
			end
			want = expected_drives.pop_front();
			if (got_l !== want.drive_l) begin
				$error("drive_left: expected %0d, got %0d", want.drive_l, got_l);
				fail_count++;
			end
			if (got_r !== want.drive_r) begin
				$error("drive_right: expected %0d, got %0d", want.drive_r, got_r);
				fail_count++;
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [31:0]      s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [39:0]      m_tdata;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [31:0]      cfg_data = '0;

	bit idling_on = 1'b1;
	int cycles = 0;
	drive_scoreboard sb;

	dual_wheel_pi_speed_loop_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("dual_wheel_pi_speed_loop_unit test failed");
			$finish;
		end
	end

	task automatic send_tick(input logic signed [PULSE_W-1:0] pl,
			input logic signed [PULSE_W-1:0] pr);
		int gap;
		gap = idling_on ? $urandom_range(0, 7) : 0;
		// keep valid high through back-to-back requests
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {pr, pl};
		do @(posedge clk); while (!s_tready);
		sb.note_tick(pl, pr);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.note_reg(idx, data);
	endtask

	task automatic set_regs(input logic [31:0] vals [7]);
		for (int i = REG_REF_L; i <= REG_DT; i++) write_reg(IDX_W'(i), vals[i]);
		write_reg(REG_UNUSED, $urandom());
		cfg_valid <= 1'b0;
	endtask

	// hold off new ticks until every drive request is back
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.expected_drives.size() != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] spread(int b);
		return $urandom_range(0, 1 << (b + 1)) - (32'd1 << b);
	endfunction

	function automatic logic [31:0] pick_reg(logic [IDX_W-1:0] idx, phase_mode_t mode);
		logic [31:0] corners [7];
		corners = '{32'h0, 32'h1, 32'h7fffffff, 32'h80000000, 32'hffffffff,
			32'h00010000, 32'h0001ffff};
		if (mode == MODE_EXTREME) return corners[$urandom_range(0, 6)];
		if (mode == MODE_WIDE) return $urandom();
		case (idx)
			REG_REF_L, REG_REF_R: return spread(17);
			REG_KP:  return spread(21);
			REG_KI:  return spread(19);
			REG_W:   return $urandom_range(0, 70000);
			REG_SPP: return $urandom_range(0, 4096);
			default: return $urandom_range(0, 8192);
		endcase
	endfunction

	function automatic logic [PULSE_W-1:0] pick_pulse(phase_mode_t mode);
		if (mode == MODE_TYPICAL) return PULSE_W'($urandom_range(0, 400)) - PULSE_W'(200);
		case ($urandom_range(0, 3))
			0: return 16'h7fff;
			1: return 16'h8000;
			default: return PULSE_W'($urandom());
		endcase
	endfunction

	initial begin
		int stall;
		wait (arst_n);
		forever begin
			stall = idling_on ? $urandom_range(0, 7) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
			sb.check_drive(m_tdata);
		end
	end

	initial begin
		logic [31:0] vals [7];
		phase_mode_t mode;
		sb = new();
		sb.clear();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults after reset, pulse extremes
		send_tick(16'sh0000, 16'sh0000);
		send_tick(16'sh7fff, 16'sh7fff);
		send_tick(16'sh8000, 16'sh8000);
		send_tick(16'sh0001, 16'shffff);
		send_tick(16'shffff, 16'sh0001);
		send_tick(16'sh0064, 16'shff9c);

		// weight above one, speed and error saturation, integral runaway
		drain();
		set_regs('{32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
			32'h0001ffff, 32'h7fffffff, 32'h7fffffff});
		send_tick(16'sh8000, 16'sh7fff);
		send_tick(16'sh7fff, 16'sh8000);
		send_tick(16'sh0000, 16'sh0000);

		// zero weight passes speed straight through
		drain();
		set_regs('{32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
			32'h00000000, 32'hffffffff, 32'h00000000});
		send_tick(16'sh8000, 16'sh7fff);
		send_tick(16'sh7fff, 16'sh8000);
		send_tick(16'sh0001, 16'sh0001);
		send_tick(16'sh0000, 16'sh0000);

		// weight exactly one, tiny gains
		drain();
		set_regs('{32'h00000000, 32'hffffffff, 32'h00000001, 32'h00000001,
			32'h00010000, 32'h00000000, 32'h00000001});
		send_tick(16'sh1234, 16'shedcb);
		send_tick(16'sh8000, 16'sh7fff);

		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p % 4)
				0, 1: mode = MODE_TYPICAL;
				2: mode = MODE_WIDE;
				default: mode = MODE_EXTREME;
			endcase
			drain();
			idling_on = (p % 5 != 4);
			for (int i = REG_REF_L; i <= REG_DT; i++) vals[i] = pick_reg(IDX_W'(i), mode);
			set_regs(vals);
			repeat (PHASE_ITEMS) send_tick(pick_pulse(mode), pick_pulse(mode));
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.fail_count == 0) begin
			$display("dual_wheel_pi_speed_loop_unit test passed");
		end else begin
			$display("dual_wheel_pi_speed_loop_unit test failed");
		end
		$finish;
	end

endmodule

// File: files.f
src/dwpi_pkg.sv
src/dwpi_mul.sv
src/dwpi_core.sv
src/dual_wheel_pi_speed_loop_unit.sv
sim/tb.sv
